// ===== design/hbbc_pkg.sv =====
// hbbc_pkg: shared types and codes for the hashed block buffer cache
// no dependencies; imported by every module of the block
package hbbc_pkg;

  localparam int unsigned BucketW = 6;   // holds a bucket number below 64
  localparam int unsigned RankW   = 7;   // search rank: home first, then bucket+1
  localparam logic [7:0]  CountMax = 8'hFF;

  typedef enum logic [1:0] {
    CmdGet     = 2'd0,
    CmdRelease = 2'd1,
    CmdPin     = 2'd2,
    CmdUnpin   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StNoFree = 2'd1,
    StCount  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    BkIdle = 2'd0,
    BkScan = 2'd1,
    BkFin  = 2'd2
  } back_state_e;

  typedef struct packed {
    cmd_e        command;
    logic [7:0]  device;
    logic [31:0] block_number;
    logic [4:0]  slot;
    logic [31:0] now_ticks;
  } req_t;

  typedef struct packed {
    logic [4:0] slot_out;
    logic       was_hit;
    logic       needs_read;
    status_e    status;
  } rsp_t;

  typedef struct packed {
    req_t               req;
    logic [BucketW-1:0] home;
  } job_t;

endpackage

// ===== design/hbbc_front.sv =====
// hbbc_front: takes request transfers and works out the home bucket of a get
// uses hbbc_pkg; feeds hbbc_queue
module hbbc_front #(
  parameter int unsigned NUM_BUCKETS = 13
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  hbbc_pkg::req_t in_data_i,
  output logic          job_valid_o,
  input  logic          job_full_i,
  output hbbc_pkg::job_t job_o
);
  import hbbc_pkg::*;

  // byte weights 256^j mod bucket count; the reciprocal is exact for sums below 2^16
  localparam logic [15:0] Fold1    = 16'(256 % NUM_BUCKETS);
  localparam logic [15:0] Fold2    = 16'(65536 % NUM_BUCKETS);
  localparam logic [15:0] Fold3    = 16'(16777216 % NUM_BUCKETS);
  localparam logic [15:0] Buckets  = 16'(NUM_BUCKETS);
  localparam int unsigned RecipSh  = 22;
  localparam logic [22:0] Recip    = 23'((4194304 + NUM_BUCKETS - 1) / NUM_BUCKETS);
  localparam logic [1:0]  StepDone = 2'd3;

  logic               busy_q;
  logic [1:0]         cnt_q;
  req_t               req_q;
  logic [15:0]        fold_q, fold_d;
  logic [15:0]        quo_q, quo_d;
  logic [BucketW-1:0] rem_q, rem_d;

  // fold, quotient, remainder: one step a cycle
  assign fold_d = 16'(req_q.block_number[7:0]) +
                  16'(req_q.block_number[15:8]) * Fold1 +
                  16'(req_q.block_number[23:16]) * Fold2 +
                  16'(req_q.block_number[31:24]) * Fold3;
  assign quo_d  = 16'((39'(fold_q) * 39'(Recip)) >> RecipSh);
  assign rem_d  = BucketW'(fold_q - quo_q * Buckets);

  assign in_stall_o  = busy_q;
  assign job_valid_o = busy_q && (cnt_q == StepDone);
  assign job_o       = '{req: req_q, home: rem_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else if (!busy_q) begin
      if (in_valid_i) begin
        busy_q <= 1'b1;
        cnt_q  <= (in_data_i.command == CmdGet) ? 2'd0 : StepDone;
      end
    end else if (cnt_q != StepDone) begin
      cnt_q <= cnt_q + 2'd1;
    end else if (!job_full_i) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && in_valid_i) begin
      req_q <= in_data_i;
    end else if (busy_q && cnt_q != StepDone) begin
      fold_q <= fold_d;
      quo_q  <= quo_d;
      rem_q  <= rem_d;
    end
  end

endmodule

// ===== design/hbbc_queue.sv =====
// hbbc_queue: two-entry queue of classified jobs between front and back
// uses hbbc_pkg
module hbbc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hbbc_pkg::job_t push_data_i,
  output logic           full_o,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output hbbc_pkg::job_t pop_data_o
);
  import hbbc_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o      = (cnt_q == 2'd2);
  assign pop_valid_o = (cnt_q != 2'd0);
  assign pop_data_o  = mem_q[rp_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop)  rp_q <= ~rp_q;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 2'd1;
      else if (!do_push && do_pop) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= push_data_i;
  end

endmodule

// ===== design/hbbc_back.sv =====
// hbbc_back: runs jobs against the entry pool, one entry per scan cycle
// uses hbbc_pkg; holds the entry store and the response register
module hbbc_back #(
  parameter int unsigned NUM_BUFFERS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  output logic           job_pop_o,
  input  hbbc_pkg::job_t job_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output hbbc_pkg::rsp_t out_data_o
);
  import hbbc_pkg::*;

  localparam int unsigned IdxW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam logic [8:0]  NumBuf = 9'(NUM_BUFFERS);
  localparam logic [8:0]  LastIdx = 9'(NUM_BUFFERS - 1);

  logic [7:0]         dev_q    [NUM_BUFFERS];
  logic [31:0]        blk_q    [NUM_BUFFERS];
  logic [BucketW-1:0] bkt_q    [NUM_BUFFERS];
  logic               val_q    [NUM_BUFFERS];
  logic [7:0]         ref_q    [NUM_BUFFERS];
  logic [31:0]        last_q   [NUM_BUFFERS];

  back_state_e            state_q, state_d;
  job_t                   job_q;
  logic [IdxW-1:0]        cnt_q;
  logic                   mf_q, vf_q;
  logic [IdxW-1:0]        midx_q, vidx_q;
  logic [RankW+31:0]      vkey_q;
  logic                   out_valid_q;
  rsp_t                   out_q, rsp_d;

  logic                   out_free, fin_go, cur_match, cur_better, scan_last;
  logic [RankW-1:0]       cur_rank;
  logic [RankW+31:0]      cur_key;
  logic [8:0]             slot9;
  logic                   slot_ok;
  logic [IdxW-1:0]        sidx;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign fin_go      = (state_q == BkFin) && out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign job_pop_o   = (state_q == BkIdle) && job_valid_i;

  assign cur_match = (dev_q[cnt_q] == job_q.req.device) &&
                     (blk_q[cnt_q] == job_q.req.block_number);
  assign cur_rank  = (bkt_q[cnt_q] == job_q.home) ? '0 :
                     RankW'(bkt_q[cnt_q]) + RankW'(1);
  assign cur_key   = {cur_rank, last_q[cnt_q]};
  // free entry released no later than now, strictly smaller key (rank, then release time) wins
  assign cur_better = (ref_q[cnt_q] == 8'd0) &&
                      (last_q[cnt_q] <= job_q.req.now_ticks) &&
                      (!vf_q || cur_key < vkey_q);
  assign scan_last = (9'(cnt_q) == LastIdx);

  assign slot9   = {4'd0, job_q.req.slot};
  assign slot_ok = slot9 < NumBuf;
  assign sidx    = slot9[IdxW-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      BkIdle: if (job_valid_i) state_d = (job_i.req.command == CmdGet) ? BkScan : BkFin;
      BkScan: if (cur_match || scan_last) state_d = BkFin;
      BkFin:  if (out_free) state_d = BkIdle;
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= BkIdle;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BkIdle && job_valid_i) begin
      job_q <= job_i;
      cnt_q <= '0;
      mf_q  <= 1'b0;
      vf_q  <= 1'b0;
    end else if (state_q == BkScan) begin
      if (cur_match) begin
        mf_q   <= 1'b1;
        midx_q <= cnt_q;
      end else begin
        if (cur_better) begin
          vf_q   <= 1'b1;
          vidx_q <= cnt_q;
          vkey_q <= cur_key;
        end
        if (!scan_last) cnt_q <= cnt_q + IdxW'(1);
      end
    end
  end

  // response of the finishing job
  always_comb begin
    logic [7:0] ix8;
    ix8   = '0;
    rsp_d = '{slot_out: job_q.req.slot, was_hit: 1'b0, needs_read: 1'b0, status: StOk};
    if (job_q.req.command == CmdGet) begin
      if (mf_q) begin
        ix8 = 8'(midx_q);
        rsp_d.slot_out = ix8[4:0];
        rsp_d.was_hit  = 1'b1;
        if (ref_q[midx_q] == CountMax) rsp_d.status = StCount;
        else rsp_d.needs_read = !val_q[midx_q];
      end else if (vf_q) begin
        ix8 = 8'(vidx_q);
        rsp_d.slot_out   = ix8[4:0];
        rsp_d.needs_read = 1'b1;
      end else begin
        rsp_d.slot_out = '0;
        rsp_d.status   = StNoFree;
      end
    end else if (slot_ok) begin
      if (job_q.req.command == CmdPin) begin
        if (ref_q[sidx] == CountMax) rsp_d.status = StCount;
      end else if (ref_q[sidx] == 8'd0) begin
        rsp_d.status = StCount;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) out_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        dev_q[i]  <= '0;
        blk_q[i]  <= '0;
        bkt_q[i]  <= '0;
        val_q[i]  <= 1'b0;
        ref_q[i]  <= '0;
        last_q[i] <= '0;
      end
    end else begin
      if (fin_go)            out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (fin_go) begin
        if (job_q.req.command == CmdGet) begin
          if (mf_q) begin
            if (ref_q[midx_q] != CountMax) begin
              ref_q[midx_q] <= ref_q[midx_q] + 8'd1;
              val_q[midx_q] <= 1'b1;
            end
          end else if (vf_q) begin
            dev_q[vidx_q] <= job_q.req.device;
            blk_q[vidx_q] <= job_q.req.block_number;
            bkt_q[vidx_q] <= job_q.home;
            ref_q[vidx_q] <= 8'd1;
            val_q[vidx_q] <= 1'b1;
          end
        end else if (slot_ok) begin
          if (job_q.req.command == CmdPin) begin
            if (ref_q[sidx] != CountMax) ref_q[sidx] <= ref_q[sidx] + 8'd1;
          end else if (ref_q[sidx] != 8'd0) begin
            ref_q[sidx] <= ref_q[sidx] - 8'd1;
            if (job_q.req.command == CmdRelease && ref_q[sidx] == 8'd1)
              last_q[sidx] <= job_q.req.now_ticks;
          end
        end
      end
    end
  end

endmodule

// ===== design/hashed_block_buffer_cache.sv =====
// hashed block buffer cache: front hashes, back scans the entry pool
// a get ends its scan at the first matching entry, else scans every entry;
// release, pin and unpin skip the scan
// front and back each take a new request only when done with the last;
// a stalled result holds the back
// reset: asynchronous, clears all entries and control state at once
module hashed_block_buffer_cache #(
  parameter int unsigned NUM_BUFFERS = 32,
  parameter int unsigned NUM_BUCKETS = 13
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  hbbc_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output hbbc_pkg::rsp_t out_data_o
);
  import hbbc_pkg::*;

  logic f_valid, q_full, q_valid, q_pop;
  job_t f_job, q_job;

  hbbc_front #(.NUM_BUCKETS(NUM_BUCKETS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .job_valid_o(f_valid), .job_full_i(q_full), .job_o(f_job)
  );

  hbbc_queue u_queue (
    .clk_i, .rst_ni, .push_i(f_valid), .push_data_i(f_job), .full_o(q_full),
    .pop_valid_o(q_valid), .pop_i(q_pop), .pop_data_o(q_job)
  );

  hbbc_back #(.NUM_BUFFERS(NUM_BUFFERS)) u_back (
    .clk_i, .rst_ni, .job_valid_i(q_valid), .job_pop_o(q_pop), .job_i(q_job),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule
